// ===== rtl/msbr_pkg.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit reader package
// Shared field widths, status and action codes, and item types.
// ----------------------------------------------------------------------------
package msbr_pkg;

  localparam int ByteBits  = 8;
  localparam int CountW    = 6;
  localparam int HeldW     = 7;
  localparam int OutW      = 32;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusUnderflow = 2'd1,
    StatusOverflow  = 2'd2
  } status_e;

  typedef enum logic {
    ActPush = 1'b0,
    ActRead = 1'b1
  } action_e;

  typedef struct packed {
    action_e               action;
    logic [ByteBits-1:0]   byte_in;
    logic [CountW-1:0]     bit_count;
  } in_item_t;

  typedef struct packed {
    logic [OutW-1:0]       bits_out;
    status_e               status;
    logic [HeldW-1:0]      bits_available;
  } out_item_t;

endpackage

// ===== rtl/msbr_in_if.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit reader request channel
// Valid/ready channel that carries one push or read request.
// ----------------------------------------------------------------------------
interface msbr_in_if;
  import msbr_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [ByteBits-1:0] byte_in;
  logic [CountW-1:0]   bit_count;

  modport source (output valid, action, byte_in, bit_count, input ready);
  modport sink   (input valid, action, byte_in, bit_count, output ready);
endinterface

// ===== rtl/msbr_out_if.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit reader result channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface msbr_out_if;
  import msbr_pkg::*;

  logic             valid;
  logic             ready;
  logic [OutW-1:0]  bits_out;
  status_e          status;
  logic [HeldW-1:0] bits_available;

  modport source (output valid, bits_out, status, bits_available, input ready);
  modport sink   (input valid, bits_out, status, bits_available, output ready);
endinterface

// ===== rtl/msbr_step.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit reader step
// Next bit store and result for one request: byte append or funnel extract.
// ----------------------------------------------------------------------------
module msbr_step #(
  parameter int BUFFER_BYTES  = 8,
  parameter int MAX_READ_BITS = 32
) (
  input  msbr_pkg::in_item_t                        item_i,
  input  logic [BUFFER_BYTES*msbr_pkg::ByteBits-1:0] store_i,
  input  logic [msbr_pkg::HeldW-1:0]                held_i,
  output logic [BUFFER_BYTES*msbr_pkg::ByteBits-1:0] store_o,
  output logic [msbr_pkg::HeldW-1:0]                held_o,
  output msbr_pkg::out_item_t                       res_o
);
  import msbr_pkg::*;

  localparam int CapBits = BUFFER_BYTES * ByteBits;
  localparam int ExtW    = (CapBits > OutW) ? CapBits : OutW;
  localparam logic [HeldW:0]    CapLimit = (HeldW+1)'(CapBits);
  localparam logic [HeldW:0]    ByteStep = (HeldW+1)'(ByteBits);
  localparam logic [CountW-1:0] MaxCnt   = CountW'(MAX_READ_BITS);

  logic [HeldW:0]            room_sum;
  logic                      push_full;
  logic [CapBits+ByteBits-1:0] appended;
  logic [CountW-1:0]         cnt;
  logic                      read_short;
  logic [HeldW-1:0]          rest;
  logic [ExtW-1:0]           store_ext;
  logic [ExtW-1:0]           extracted;
  logic [CapBits-1:0]        keep_mask;

  always_comb begin
    // push path
    room_sum  = {1'b0, held_i} + ByteStep;
    push_full = room_sum > CapLimit;
    appended  = {store_i, item_i.byte_in};

    // read path: saturate count, extract from the top of the held bits
    cnt        = (item_i.bit_count > MaxCnt) ? MaxCnt : item_i.bit_count;
    read_short = {1'b0, cnt} > held_i;
    rest       = held_i - {1'b0, cnt};
    store_ext  = ExtW'(store_i);
    extracted  = (store_ext >> rest) & ~({ExtW{1'b1}} << cnt);
    keep_mask  = ~({CapBits{1'b1}} << rest);
  end

  always_comb begin
    store_o      = store_i;
    held_o       = held_i;
    res_o.bits_out = '0;
    res_o.status   = StatusOk;
    unique case (item_i.action)
      ActPush: begin
        if (push_full) begin
          res_o.status = StatusOverflow;
        end else begin
          store_o = appended[CapBits-1:0];
          held_o  = room_sum[HeldW-1:0];
        end
      end
      ActRead: begin
        if (read_short) begin
          res_o.status = StatusUnderflow;
        end else begin
          store_o        = store_i & keep_mask;
          held_o         = rest;
          res_o.bits_out = extracted[OutW-1:0];
        end
      end
      default: res_o.status = StatusOk;
    endcase
    res_o.bits_available = held_o;
  end

endmodule

// ===== rtl/msb_first_bit_reader_unit.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit reader unit
// Byte-fed bit buffer that serves right-aligned MSB-first bit fields.
// ----------------------------------------------------------------------------
// Requests are either a byte push (appended at the tail of a buffer of
// BUFFER_BYTES bytes) or a read of 0 to MAX_READ_BITS bits (larger counts
// saturate), returned right-aligned with the oldest bit most significant;
// only the 32 least significant bits of a wider read are returned. Every
// request produces exactly one result carrying the bits read, a status
// (ok, underflow on a read asking for more than is held, overflow on a
// push with less than a byte of room) and the number of bits held
// afterwards. A failed request leaves the buffer untouched. Throughput is
// one request per cycle while the result side keeps up; an accepted
// request is loaded into the request register, and the single
// funnel-shift/append step on the bit store then writes the result
// register, which presents the result.
// Backpressure on the result side stalls the request register, and the
// request side keeps accepting while the request register is free or
// draining.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_unit #(
  parameter int BUFFER_BYTES  = 8,
  parameter int MAX_READ_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  msbr_in_if.sink           in_i,
  msbr_out_if.source        out_o
);
  import msbr_pkg::*;

  localparam int CapBits = BUFFER_BYTES * ByteBits;

  // request register
  logic      req_valid_q;
  in_item_t  req_q;
  // result register
  logic      res_valid_q;
  out_item_t res_q;
  // bit store
  logic [CapBits-1:0] store_q, store_d;
  logic [HeldW-1:0]   held_q, held_d;
  out_item_t          res_d;

  logic step_fire;
  logic req_take;

  // advance the step when a request waits and the result slot is free or draining
  assign step_fire = req_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !req_valid_q || step_fire;
  assign req_take   = in_i.valid && in_i.ready;

  msbr_step #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .MAX_READ_BITS(MAX_READ_BITS)
  ) u_step (
    .item_i (req_q),
    .store_i(store_q),
    .held_i (held_q),
    .store_o(store_d),
    .held_o (held_d),
    .res_o  (res_d)
  );

  // request register: load on accept, drop when consumed by the step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_take) begin
      req_valid_q <= 1'b1;
    end else if (step_fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_take) begin
      req_q.action    <= action_e'(in_i.action);
      req_q.byte_in   <= in_i.byte_in;
      req_q.bit_count <= in_i.bit_count;
    end
  end

  // bit store: commit the step's next state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      held_q  <= '0;
    end else if (step_fire) begin
      store_q <= store_d;
      held_q  <= held_d;
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_fire) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.bits_out       = res_q.bits_out;
  assign out_o.status         = res_q.status;
  assign out_o.bits_available = res_q.bits_available;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(CapBits))
    else $error("held bit count exceeds buffer capacity");

  a_store_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store_q >> held_q) == '0)
    else $error("bit store holds stale bits above the held ones");

  a_result_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_fire |=> (res_q.bits_available == held_q))
    else $error("reported bit count differs from the committed state");

  a_fail_no_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.status != StatusOk) |-> (res_q.bits_out == '0))
    else $error("failed request returned bits");

  a_state_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_fire |=> ($stable(held_q) && $stable(store_q)))
    else $error("bit store changed without a request");

endmodule

// ===== tb/tb_msb_first_bit_reader_unit.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit reader unit testbench
// Drives byte pushes and bit reads through the request channel and checks
// every result against a cycle-free prediction of the bit buffer.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_reader_unit;
  import msbr_pkg::*;

  localparam int BufferBytes  = 8;
  localparam int MaxReadBits  = 32;
  localparam int CapacityBits = BufferBytes * ByteBits;
  localparam int CountMax     = (1 << CountW) - 1;
  localparam int ResetCycles  = 11;
  localparam int DrainCycles  = 8;
  localparam int CycleLimit   = 200000;
  localparam int ShownLimit   = 10;
  localparam int PhaseCount   = 8;
  localparam int PhaseItems   = 181;

  // Idle patterns applied to the two channels, one per phase of the run.
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct {
    in_item_t   req;
    idle_mode_e mode;
  } queued_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  msbr_in_if  req_if ();
  msbr_out_if res_if ();

  msb_first_bit_reader_unit #(
    .BUFFER_BYTES  (BufferBytes),
    .MAX_READ_BITS (MaxReadBits)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // Requests waiting to be driven, and results owed by the unit, in order.
  queued_req_t request_queue [$];
  out_item_t   pending_results [$];

  // Shadow of the bit buffer: held bits right-aligned, oldest bit on top.
  logic [CapacityBits-1:0] shadow_store = '0;
  int unsigned             shadow_held  = 0;

  idle_mode_e cur_mode    = IdleNone;
  int         error_count = 0;
  int         result_index = 0;
  int         cycle_count = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [CapacityBits-1:0] low_mask(int unsigned n);
    if (n >= CapacityBits) return '1;
    return (CapacityBits'(1) << n) - 1;
  endfunction

  // Advance the shadow buffer by one request and return the result it owes.
  function automatic out_item_t next_reader_result(in_item_t req);
    out_item_t   res;
    int unsigned n;
    int unsigned rest;
    res        = '0;
    res.status = StatusOk;
    if (req.action == ActPush) begin
      // Drop the byte when less than a byte of room is left.
      if (shadow_held + ByteBits > CapacityBits) begin
        res.status = StatusOverflow;
      end else begin
        shadow_store = (shadow_store << ByteBits) | CapacityBits'(req.byte_in);
        shadow_held += ByteBits;
      end
    end else begin
      // Saturate oversized counts before anything else.
      n = req.bit_count;
      if (n > MaxReadBits) n = MaxReadBits;
      if (n > shadow_held) begin
        res.status = StatusUnderflow;
      end else if (n > 0) begin
        rest         = shadow_held - n;
        res.bits_out = OutW'((shadow_store >> rest) & low_mask(n));
        shadow_held  = rest;
        shadow_store &= low_mask(rest);
      end
    end
    res.bits_available = HeldW'(shadow_held);
    return res;
  endfunction

  function automatic int unsigned idle_pct(idle_mode_e mode, bit receiver_side);
    case (mode)
      IdleSender:   return receiver_side ? 0 : 51;
      IdleReceiver: return receiver_side ? 51 : 0;
      IdleBoth:     return 23;
      default:      return 0;
    endcase
  endfunction

  function automatic bit chance(int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  task automatic note_failure(string msg);
    error_count++;
    if (error_count <= ShownLimit) $display("%s", msg);
  endtask

  task automatic queue_request(action_e act, logic [ByteBits-1:0] data,
                               logic [CountW-1:0] count, idle_mode_e mode);
    queued_req_t q;
    q.req.action    = act;
    q.req.byte_in   = data;
    q.req.bit_count = count;
    q.mode          = mode;
    request_queue.insert(request_queue.size(), q);
  endtask

  // Request driver: record accepted requests, then offer the next one unless
  // the current phase calls for a gap. Hold valid high across back-to-back
  // requests so it gets a single update per edge.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    in_item_t    accepted;
    queued_req_t nxt;
    logic        fire;
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.action    <= ActPush;
      req_if.byte_in   <= '0;
      req_if.bit_count <= '0;
    end else begin
      fire = req_if.valid && req_if.ready;
      if (fire) begin
        accepted.action    = action_e'(req_if.action);
        accepted.byte_in   = req_if.byte_in;
        accepted.bit_count = req_if.bit_count;
        pending_results.insert(pending_results.size(), next_reader_result(accepted));
      end
      if (!req_if.valid || fire) begin
        if (request_queue.size() != 0 &&
            !chance(idle_pct(request_queue[0].mode, 1'b0))) begin
          nxt = request_queue.pop_front();
          req_if.valid     <= 1'b1;
          req_if.action    <= nxt.req.action;
          req_if.byte_in   <= nxt.req.byte_in;
          req_if.bit_count <= nxt.req.bit_count;
          cur_mode         <= nxt.mode;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest one owed,
  // then stall the next cycle at the rate the current phase asks for.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    out_item_t owed;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result with no request: bits=%h status=%0d held=%0d",
                                 res_if.bits_out, res_if.status, res_if.bits_available));
        end else begin
          owed = pending_results.pop_front();
          if (res_if.bits_out !== owed.bits_out || res_if.status !== owed.status ||
              res_if.bits_available !== owed.bits_available) begin
            note_failure($sformatf(
              "result %0d: expected bits=%h status=%0d held=%0d, got bits=%h status=%0d held=%0d",
              result_index, owed.bits_out, owed.status, owed.bits_available,
              res_if.bits_out, res_if.status, res_if.bits_available));
          end
          result_index++;
        end
      end
      res_if.ready <= !chance(idle_pct(cur_mode, 1'b1));
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[msb_first_bit_reader_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned fill_level;
    int unsigned n;
    int unsigned top;
    int          mode_order [PhaseCount];
    idle_mode_e  mode;
    action_e     act;
    logic [ByteBits-1:0] data;
    logic [CountW-1:0]   count;

    mode_order = '{0, 1, 2, 3, 0, 3, 2, 1};

    // Drive every input to a known value before the first edge.
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.action    = ActPush;
    req_if.byte_in   = '0;
    req_if.bit_count = '0;
    res_if.ready     = 1'b0;

    // Directed part: empty-buffer reads, zero count, filling to the brim,
    // overflow with a partial byte of room, saturated counts, exact drain.
    queue_request(ActRead, 8'hFF, 6'd8, IdleNone);    // underflow on empty
    queue_request(ActRead, 8'h00, 6'd0, IdleNone);    // zero count on empty
    queue_request(ActPush, 8'h00, 6'h3F, IdleNone);
    queue_request(ActPush, 8'hFF, 6'h00, IdleNone);
    queue_request(ActPush, 8'hA5, 6'h15, IdleNone);
    queue_request(ActPush, 8'h5A, 6'h2A, IdleNone);
    queue_request(ActPush, 8'h01, 6'h01, IdleNone);
    queue_request(ActPush, 8'h80, 6'h20, IdleNone);
    queue_request(ActPush, 8'hC3, 6'h3F, IdleNone);
    queue_request(ActPush, 8'h3C, 6'h00, IdleNone);   // buffer now full
    queue_request(ActRead, 8'h00, 6'd3, IdleNone);    // leave 3 bits of room
    queue_request(ActPush, 8'hFF, 6'h3F, IdleNone);   // overflow
    queue_request(ActRead, 8'hFF, 6'd63, IdleNone);   // saturates to max
    queue_request(ActRead, 8'hFF, 6'd0, IdleNone);    // zero count
    queue_request(ActRead, 8'h55, 6'd1, IdleNone);
    queue_request(ActRead, 8'hAA, 6'd7, IdleNone);
    queue_request(ActRead, 8'h00, 6'd33, IdleNone);   // saturated, still too many
    queue_request(ActRead, 8'h00, 6'd21, IdleNone);   // drain exactly
    queue_request(ActPush, 8'h96, 6'd9, IdleNone);
    queue_request(ActRead, 8'h00, 6'd9, IdleNone);    // one bit short
    queue_request(ActRead, 8'hFF, 6'd8, IdleNone);

    // Random part: mostly well-formed traffic that keeps the buffer busy in
    // the middle of its range, with a share of arbitrary requests as noise.
    fill_level = 0;
    for (int p = 0; p < PhaseCount; p++) begin
      mode = idle_mode_e'(mode_order[p]);
      for (int k = 0; k < PhaseItems; k++) begin
        data = ByteBits'($urandom);
        if ($urandom_range(0, 99) < 8) begin
          act   = action_e'($urandom_range(0, 1));
          count = CountW'($urandom_range(0, CountMax));
        end else if (fill_level + ByteBits <= CapacityBits &&
                     (fill_level < ByteBits ||
                      $urandom_range(0, CapacityBits - 1) >= fill_level)) begin
          act   = ActPush;
          count = CountW'($urandom);
        end else begin
          act   = ActRead;
          top   = (fill_level < MaxReadBits) ? fill_level : MaxReadBits;
          count = CountW'($urandom_range(1, top));
        end
        queue_request(act, data, count, mode);
        // Track the fill level so later picks stay well-formed.
        if (act == ActPush) begin
          if (fill_level + ByteBits <= CapacityBits) fill_level += ByteBits;
        end else begin
          n = (count > MaxReadBits) ? MaxReadBits : count;
          if (n <= fill_level) fill_level -= n;
        end
      end
    end

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for every request to go out and every result to come back.
    while (request_queue.size() != 0 || req_if.valid || pending_results.size() != 0)
      @(posedge clk_i);
    // Leave room for a stray result to show up.
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("[msb_first_bit_reader_unit] OK");
    end else begin
      $display("[msb_first_bit_reader_unit] ERROR");
    end
    $finish;
  end

endmodule
